>>> src/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and constants of the first-fit bin allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

    localparam int CAP_W            = 13;
    localparam int REQ_W            = 13;
    localparam int DEF_NUM_BINS     = 10;
    localparam int DEF_MAX_CAPACITY = 4096;
    localparam logic [CAP_W-1:0] CAP_RESET = 13'd4096;

    typedef enum logic
    {
        OP_CLEAR = 1'b0,
        OP_ALLOC = 1'b1
    } op_t;

    // Per-cycle command broadcast to every cell of the row.
    typedef struct packed
    {
        logic clear;
        logic alloc;
    } cell_ctl_t;

endpackage

>>> src/ffba_cell.sv
// ----------------------------------------------------------------------------
// ffba_cell
// One bin: holds its fill level and touched flag, tests the request and
// passes the claim bit on to the next higher bin.
// ----------------------------------------------------------------------------
module ffba_cell #(
    parameter int OFF_W = 12,
    parameter int SUM_W = 14
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  ffba_pkg::cell_ctl_t        ctl,
    input  logic [ffba_pkg::REQ_W-1:0] req,
    input  logic [SUM_W-1:0]           cap,
    input  logic                       claim_in,
    output logic                       claim_out,
    output logic                       grant,
    output logic [OFF_W-1:0]           fill,
    output logic                       touched_next
);
    import ffba_pkg::*;

    logic [OFF_W-1:0] fill_reg;
    logic [OFF_W-1:0] fill_next;
    logic             touched_reg;
    logic [SUM_W-1:0] sum;
    logic             fits;

    assign sum       = SUM_W'(fill_reg) + SUM_W'(req);
    assign fits      = ctl.alloc && (sum < cap);
    assign grant     = fits && !claim_in;
    assign claim_out = claim_in || fits;
    assign fill      = fill_reg;

    always_comb
    begin
        if (ctl.clear)
        begin
            fill_next    = '0;
            touched_next = 1'b0;
        end
        else if (grant)
        begin
            // The new fill stays below the capacity, so it fits the field.
            fill_next    = sum[OFF_W-1:0];
            touched_next = 1'b1;
        end
        else
        begin
            fill_next    = fill_reg;
            touched_next = touched_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg    <= '0;
            touched_reg <= 1'b0;
        end
        else
        begin
            fill_reg    <= fill_next;
            touched_reg <= touched_next;
        end
    end

endmodule

>>> src/first_fit_bin_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_bin_allocator
// Keeps a fill level per bin and grants each request to the lowest bin that
// still has room, reporting the bin, the start offset and the touched mask.
// ----------------------------------------------------------------------------
// Latency: the result word appears on the cycle after start, with done high.
// Throughput: one word per cycle; busy never rises, since the row of cells
// tests all bins and updates the chosen fill as it takes the command.
// The receiver cannot stall; each result is shown for exactly one cycle.
// Reset empties every bin, clears the touched flags and sets the capacity
// register to 4096; no clearing sweep is needed.
// ----------------------------------------------------------------------------
module first_fit_bin_allocator #(
    parameter int NUM_BINS     = ffba_pkg::DEF_NUM_BINS,
    parameter int MAX_CAPACITY = ffba_pkg::DEF_MAX_CAPACITY,
    parameter int IDX_W        = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1,
    parameter int OFF_W        = $clog2(MAX_CAPACITY)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // Command channel.
    input  logic                       start,
    output logic                       busy,
    input  logic                       op,
    input  logic [ffba_pkg::REQ_W-1:0] request_count,
    // Result channel.
    output logic                       done,
    output logic                       granted,
    output logic [IDX_W-1:0]           bin_index,
    output logic [OFF_W-1:0]           bin_offset,
    output logic [NUM_BINS-1:0]        touched_mask,
    // Capacity register write channel.
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [ffba_pkg::CAP_W-1:0] cfg_data
);
    import ffba_pkg::*;

    // The sum of a fill and a request needs one bit more than either. Since
    // OFF_W + 1 bits can hold MAX_CAPACITY, the clamped capacity fits too.
    localparam int SUM_W = ((OFF_W > REQ_W) ? OFF_W : REQ_W) + 1;
    localparam logic [SUM_W-1:0] CAP_LIMIT = SUM_W'(MAX_CAPACITY);

    logic [CAP_W-1:0]    cap_reg;
    logic [SUM_W-1:0]    cap_ext;
    logic [SUM_W-1:0]    cap_eff;
    logic                accept;
    cell_ctl_t           ctl;

    logic [NUM_BINS:0]   claim;
    logic [NUM_BINS-1:0] grant;
    logic [NUM_BINS-1:0] touched_next;
    logic [OFF_W-1:0]    fill [NUM_BINS];

    logic                done_reg;
    logic                granted_reg;
    logic [IDX_W-1:0]    index_reg;
    logic [IDX_W-1:0]    index_next;
    logic [OFF_W-1:0]    offset_reg;
    logic [OFF_W-1:0]    offset_next;
    logic [NUM_BINS-1:0] mask_reg;

    // Every cycle can take a command, and the capacity register is always
    // ready for a write.
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            cap_reg <= cfg_data;
        end
    end

    // A programmed capacity above the bin size is clamped to the bin size.
    assign cap_ext = SUM_W'(cap_reg);
    assign cap_eff = (cap_ext > CAP_LIMIT) ? CAP_LIMIT : cap_ext;

    assign ctl.clear = accept && (op == OP_CLEAR);
    assign ctl.alloc = accept && (op == OP_ALLOC);

    // The claim bit enters the row at bin zero and is set by the first bin
    // that fits, so every higher bin sees the request as already taken.
    assign claim[0] = 1'b0;

    for (genvar i = 0; i < NUM_BINS; i++)
    begin : g_cell
        ffba_cell #(
            .OFF_W (OFF_W),
            .SUM_W (SUM_W)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctl          (ctl),
            .req          (request_count),
            .cap          (cap_eff),
            .claim_in     (claim[i]),
            .claim_out    (claim[i+1]),
            .grant        (grant[i]),
            .fill         (fill[i]),
            .touched_next (touched_next[i])
        );
    end

    // At most one bin grants, so the index and offset are plain OR
    // reductions over the one-hot grant vector.
    always_comb
    begin
        index_next  = '0;
        offset_next = '0;
        for (int i = 0; i < NUM_BINS; i++)
        begin
            if (grant[i])
            begin
                index_next  = index_next | IDX_W'(i);
                offset_next = offset_next | fill[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            granted_reg <= claim[NUM_BINS];
            index_reg   <= index_next;
            offset_reg  <= offset_next;
            mask_reg    <= touched_next;
        end
    end

    assign done         = done_reg;
    assign granted      = granted_reg;
    assign bin_index    = index_reg;
    assign bin_offset   = offset_reg;
    assign touched_mask = mask_reg;

endmodule

>>> src/ffba_checker.sv
// ----------------------------------------------------------------------------
// ffba_checker
// Port-level checks of the first-fit bin allocator, bound to the top level.
// ----------------------------------------------------------------------------
module ffba_checker #(
    parameter int NUM_BINS = 10,
    parameter int IDX_W    = 4,
    parameter int OFF_W    = 12
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic                       busy,
    input  logic                       op,
    input  logic                       done,
    input  logic                       granted,
    input  logic [IDX_W-1:0]           bin_index,
    input  logic [OFF_W-1:0]           bin_offset,
    input  logic [NUM_BINS-1:0]        touched_mask
);
    import ffba_pkg::*;

    // Every accepted command yields exactly one result on the next cycle.
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("accepted command gave no result");

    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |=> !done)
        else $error("result without a command");

    // A clear starts the frame with nothing touched and nothing granted.
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && op == OP_CLEAR) |=> (!granted && touched_mask == '0))
        else $error("clear result not empty");

    // A refusal reports zeros; a grant names a real bin that is now touched.
    a_refuse: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !granted) |-> (bin_index == '0 && bin_offset == '0))
        else $error("refused result carries a bin or offset");

    a_grant: assert property (@(posedge clk) disable iff (!rst_n)
        (done && granted) |->
            (32'(bin_index) < NUM_BINS && touched_mask[bin_index]))
        else $error("granted bin invalid or not touched");

endmodule

bind first_fit_bin_allocator ffba_checker #(
    .NUM_BINS (NUM_BINS),
    .IDX_W    (IDX_W),
    .OFF_W    (OFF_W)
) u_ffba_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .op            (op),
    .done          (done),
    .granted       (granted),
    .bin_index     (bin_index),
    .bin_offset    (bin_offset),
    .touched_mask  (touched_mask)
);
